>>> design/wwrl_pkg.sv
// Package for the weighted window rate limiter.
// Holds field widths, register indexes, reset values, the controller
// state type and the command/status structs between controller and datapath.
package wwrl_pkg;

    localparam int DEF_NUM_GROUPS = 4;
    localparam int DEF_MAX_LIMIT  = 64;
    localparam int DEF_TIME_BITS  = 40;

    localparam int CFG_GROUPS   = 4;
    localparam int WINDOW_W     = 24;
    localparam int LIMIT_W      = 7;
    localparam int WEIGHT_W     = 7;
    localparam int GROUP_W      = 2;
    localparam int FILL_OUT_W   = 7;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_G0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_G3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_G0  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_G3  = 4'd7;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd1000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd64;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DT,
        S_MUL,
        S_CMP,
        S_PUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic clear_all;
        logic rd_en;
        logic latch_dt;
        logic latch_prod;
        logic mark_refuse;
        logic push;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_clear;
        logic bad_group;
        logic zero_weight;
        logic need_test;
        logic fill_zero;
        logic rate_refuse;
        logic push_last;
    } t_dp_status;

endpackage

>>> design/wwrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module wwrl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/wwrl_dp.sv
// Datapath: configuration registers, per-group ring pointers, stamp RAM,
// rate test arithmetic and the output register.
// Depends on wwrl_pkg and wwrl_ram.
module wwrl_dp #(
    parameter int NUM_GROUPS = wwrl_pkg::DEF_NUM_GROUPS,
    parameter int MAX_LIMIT  = wwrl_pkg::DEF_MAX_LIMIT,
    parameter int TIME_BITS  = wwrl_pkg::DEF_TIME_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wwrl_pkg::t_dp_cmd                 i_cmd,
    output wwrl_pkg::t_dp_status              o_status,
    input  logic                              i_command,
    input  logic [wwrl_pkg::GROUP_W-1:0]      i_group,
    input  logic [wwrl_pkg::WEIGHT_W-1:0]     i_weight,
    input  logic [TIME_BITS-1:0]              i_now_ms,
    input  logic                              i_cfg_we,
    input  logic [wwrl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wwrl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_exceeded,
    output logic [wwrl_pkg::FILL_OUT_W-1:0]   o_fill_count
);

    localparam int CAP_W  = $clog2(MAX_LIMIT + 1);
    localparam int IDX_W  = $clog2(MAX_LIMIT);
    localparam int DEPTH  = NUM_GROUPS * MAX_LIMIT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int GI_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int SUM_W  = ((CAP_W > wwrl_pkg::WEIGHT_W) ? CAP_W : wwrl_pkg::WEIGHT_W) + 1;
    localparam int LHS_W  = SUM_W + wwrl_pkg::WINDOW_W;
    localparam int DTL_W  = (TIME_BITS < LHS_W) ? TIME_BITS : LHS_W;
    localparam int RHS_W  = CAP_W + DTL_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int LCMP_W = (CAP_W > wwrl_pkg::LIMIT_W) ? CAP_W : wwrl_pkg::LIMIT_W;

    logic [wwrl_pkg::WINDOW_W-1:0] r_window [wwrl_pkg::CFG_GROUPS];
    logic [wwrl_pkg::LIMIT_W-1:0]  r_limit  [wwrl_pkg::CFG_GROUPS];
    logic [CAP_W-1:0]              r_fill   [NUM_GROUPS];
    logic [IDX_W-1:0]              r_oldest [NUM_GROUPS];

    logic                          r_command;
    logic [wwrl_pkg::GROUP_W-1:0]  r_group;
    logic [wwrl_pkg::WEIGHT_W-1:0] r_weight;
    logic [wwrl_pkg::WEIGHT_W-1:0] r_left;
    logic [TIME_BITS-1:0]          r_now;
    logic                          r_refuse;
    logic                          r_dt_zero;
    logic                          r_dt_big;
    logic [DTL_W-1:0]              r_dt_low;
    logic [LHS_W-1:0]              r_lhs;
    logic [RHS_W-1:0]              r_rhs;
    logic                          r_out_exc;
    logic [wwrl_pkg::FILL_OUT_W-1:0] r_out_fill;

    logic                          bad_group;
    logic [GI_W-1:0]               gi;
    logic [LCMP_W-1:0]             lim_ext;
    logic [CAP_W-1:0]              cap;
    logic [CAP_W-1:0]              fill_cur;
    logic [IDX_W-1:0]              oldest_cur;
    logic [SUM_W-1:0]              sum;
    logic [CAP_W:0]                slot_sum;
    logic [IDX_W-1:0]              slot_grow;
    logic [CAP_W-1:0]              oldest_inc;
    logic [IDX_W-1:0]              oldest_next;
    logic                          push_grow;
    logic [ADDR_W-1:0]             base;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic [TIME_BITS-1:0]          rd_data;
    logic [TIME_BITS-1:0]          dt;
    logic                          cfg_win_we;
    logic                          cfg_lim_we;
    logic [wwrl_pkg::GROUP_W-1:0]  cfg_grp;
    logic [wwrl_pkg::GROUP_W-1:0]  cfg_win_grp;
    logic                          cfg_grp_ok;

    always_comb begin
        bad_group = int'(r_group) >= NUM_GROUPS;
        gi        = bad_group ? '0 : GI_W'(r_group);
        lim_ext   = LCMP_W'(r_limit[r_group]);
        if (lim_ext == '0) begin
            cap = CAP_W'(1);
        end else if (lim_ext > LCMP_W'(MAX_LIMIT)) begin
            cap = CAP_W'(MAX_LIMIT);
        end else begin
            cap = CAP_W'(lim_ext);
        end
        fill_cur   = r_fill[gi];
        oldest_cur = r_oldest[gi];
        sum        = SUM_W'(fill_cur) + SUM_W'(r_weight);
        push_grow  = fill_cur < cap;
        slot_sum   = (CAP_W + 1)'(oldest_cur) + (CAP_W + 1)'(fill_cur);
        if (slot_sum >= (CAP_W + 1)'(cap)) begin
            slot_grow = IDX_W'(slot_sum - (CAP_W + 1)'(cap));
        end else begin
            slot_grow = IDX_W'(slot_sum);
        end
        oldest_inc  = CAP_W'(oldest_cur) + CAP_W'(1);
        oldest_next = (oldest_inc == cap) ? '0 : IDX_W'(oldest_inc);
        base    = ADDR_W'(gi) * ADDR_W'(MAX_LIMIT);
        wr_addr = base + ADDR_W'(push_grow ? slot_grow : oldest_cur);
        rd_addr = base + ADDR_W'(oldest_cur);
        dt      = r_now - rd_data;
    end

    always_comb begin
        cfg_win_we  = i_cfg_we && (i_cfg_index inside {[wwrl_pkg::REG_WINDOW_G0 :
                                                        wwrl_pkg::REG_WINDOW_G3]});
        cfg_lim_we  = i_cfg_we && (i_cfg_index inside {[wwrl_pkg::REG_LIMIT_G0 :
                                                        wwrl_pkg::REG_LIMIT_G3]});
        cfg_win_grp = wwrl_pkg::GROUP_W'(i_cfg_index - wwrl_pkg::REG_WINDOW_G0);
        cfg_grp     = wwrl_pkg::GROUP_W'(i_cfg_index - wwrl_pkg::REG_LIMIT_G0);
        cfg_grp_ok  = int'(cfg_grp) < NUM_GROUPS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < wwrl_pkg::CFG_GROUPS; g++) begin
                r_window[g] <= wwrl_pkg::WINDOW_RESET;
                r_limit[g]  <= wwrl_pkg::LIMIT_RESET;
            end
        end else begin
            if (cfg_win_we) begin
                r_window[cfg_win_grp] <= i_cfg_data[wwrl_pkg::WINDOW_W-1:0];
            end
            if (cfg_lim_we) begin
                r_limit[cfg_grp] <= i_cfg_data[wwrl_pkg::LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_fill[g]   <= '0;
                r_oldest[g] <= '0;
            end
        end else if (i_cmd.clear_all) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_fill[g]   <= '0;
                r_oldest[g] <= '0;
            end
        end else if (i_cmd.push) begin
            if (push_grow) begin
                r_fill[gi] <= fill_cur + CAP_W'(1);
            end else begin
                r_oldest[gi] <= oldest_next;
            end
        end else if (cfg_lim_we && cfg_grp_ok) begin
            r_fill[GI_W'(cfg_grp)]   <= '0;
            r_oldest[GI_W'(cfg_grp)] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refuse <= 1'b0;
            r_left   <= '0;
        end else begin
            if (i_cmd.load_req) begin
                r_refuse <= 1'b0;
                r_left   <= i_weight;
            end else begin
                if (i_cmd.mark_refuse) begin
                    r_refuse <= 1'b1;
                end
                if (i_cmd.push) begin
                    r_left <= r_left - wwrl_pkg::WEIGHT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_command <= i_command;
            r_group   <= i_group;
            r_weight  <= i_weight;
            r_now     <= i_now_ms;
        end
        if (i_cmd.latch_dt) begin
            r_dt_zero <= dt == '0;
            r_dt_big  <= (dt >> LHS_W) != '0;
            r_dt_low  <= DTL_W'(dt);
        end
        if (i_cmd.latch_prod) begin
            r_lhs <= LHS_W'(sum) * LHS_W'(r_window[r_group]);
            r_rhs <= RHS_W'(cap) * RHS_W'(r_dt_low);
        end
        if (i_cmd.load_out) begin
            r_out_exc  <= r_refuse;
            r_out_fill <= bad_group ? '0 : wwrl_pkg::FILL_OUT_W'(fill_cur);
        end
    end

    wwrl_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_now),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        o_status.is_clear    = r_command == wwrl_pkg::CMD_CLEAR;
        o_status.bad_group   = bad_group;
        o_status.zero_weight = r_weight == '0;
        o_status.need_test   = sum >= SUM_W'(cap);
        o_status.fill_zero   = fill_cur == '0;
        o_status.rate_refuse = r_dt_zero ||
                               (!r_dt_big && (CMP_W'(r_rhs) <= CMP_W'(r_lhs)));
        o_status.push_last   = r_left == wwrl_pkg::WEIGHT_W'(1);
    end

    assign o_exceeded   = r_out_exc;
    assign o_fill_count = r_out_fill;

endmodule

>>> design/wwrl_ctrl.sv
// Controller state machine: sequences accept, rate test, ring pushes and
// result hand-off. Drives datapath commands from datapath status.
// Depends on wwrl_pkg.
module wwrl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  wwrl_pkg::t_dp_status i_status,
    output wwrl_pkg::t_dp_cmd    o_cmd
);

    wwrl_pkg::t_state r_state;
    wwrl_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wwrl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        out_free    = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = r_state == wwrl_pkg::S_IDLE;
        case (r_state)
            wwrl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = wwrl_pkg::S_EVAL;
                end
            end
            wwrl_pkg::S_EVAL: begin
                if (i_status.is_clear) begin
                    o_cmd.clear_all = 1'b1;
                    n_state         = wwrl_pkg::S_DONE;
                end else if (i_status.bad_group || i_status.zero_weight) begin
                    n_state = wwrl_pkg::S_DONE;
                end else if (!i_status.need_test) begin
                    n_state = wwrl_pkg::S_PUSH;
                end else if (i_status.fill_zero) begin
                    o_cmd.mark_refuse = 1'b1;
                    n_state           = wwrl_pkg::S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = wwrl_pkg::S_DT;
                end
            end
            wwrl_pkg::S_DT: begin
                o_cmd.latch_dt = 1'b1;
                n_state        = wwrl_pkg::S_MUL;
            end
            wwrl_pkg::S_MUL: begin
                o_cmd.latch_prod = 1'b1;
                n_state          = wwrl_pkg::S_CMP;
            end
            wwrl_pkg::S_CMP: begin
                if (i_status.rate_refuse) begin
                    o_cmd.mark_refuse = 1'b1;
                    n_state           = wwrl_pkg::S_DONE;
                end else begin
                    n_state = wwrl_pkg::S_PUSH;
                end
            end
            wwrl_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_status.push_last) begin
                    n_state = wwrl_pkg::S_DONE;
                end
            end
            wwrl_pkg::S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = wwrl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wwrl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/weighted_window_rate_limiter_top.sv
// Weighted window rate limiter, top level. A request is accepted in S_IDLE and
// judged in S_EVAL. Clear, unknown group, zero weight or an empty group
// refusal go straight to S_DONE; a rate test runs through S_DT, S_MUL and
// S_CMP, and an admitted request writes one ring stamp per unit of weight in
// S_PUSH. One request in flight: the next request is accepted in the cycle after
// the result loads in S_DONE; a held result stalls input.
// Synchronous active-low reset: windows 1000, limits 64, all rings empty.
module weighted_window_rate_limiter_top #(
    parameter int NUM_GROUPS = wwrl_pkg::DEF_NUM_GROUPS,
    parameter int MAX_LIMIT  = wwrl_pkg::DEF_MAX_LIMIT,
    parameter int TIME_BITS  = wwrl_pkg::DEF_TIME_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic [wwrl_pkg::GROUP_W-1:0]    i_group,
    input  logic [wwrl_pkg::WEIGHT_W-1:0]   i_weight,
    input  logic [TIME_BITS-1:0]            i_now_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_exceeded,
    output logic [wwrl_pkg::FILL_OUT_W-1:0] o_fill_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wwrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wwrl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wwrl_pkg::t_dp_cmd    dp_cmd;
    wwrl_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    wwrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    wwrl_dp #(
        .NUM_GROUPS (NUM_GROUPS),
        .MAX_LIMIT  (MAX_LIMIT),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_command    (i_command),
        .i_group      (i_group),
        .i_weight     (i_weight),
        .i_now_ms     (i_now_ms),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_exceeded   (o_exceeded),
        .o_fill_count (o_fill_count)
    );

endmodule

>>> tb/wwrl_admission_checker.sv
`timescale 1ns / 100ps
// Admission checker for the weighted window rate limiter: mirrors register writes,
// predicts each request's verdict and fill count, and compares results in order.
// Depends on wwrl_pkg for field widths, register indexes and command codes.
module wwrl_admission_checker #(
    parameter int NUM_GROUPS = wwrl_pkg::DEF_NUM_GROUPS,
    parameter int MAX_LIMIT  = wwrl_pkg::DEF_MAX_LIMIT,
    parameter int TIME_BITS  = wwrl_pkg::DEF_TIME_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_command,
    input  logic [wwrl_pkg::GROUP_W-1:0]    i_group,
    input  logic [wwrl_pkg::WEIGHT_W-1:0]   i_weight,
    input  logic [TIME_BITS-1:0]            i_now_ms,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_exceeded,
    input  logic [wwrl_pkg::FILL_OUT_W-1:0] i_fill_count,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [wwrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wwrl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import wwrl_pkg::*;

    typedef struct packed {
        logic                  exceeded;
        logic [FILL_OUT_W-1:0] fill;
    } t_verdict;

    logic [TIME_BITS-1:0] stamp_ring [NUM_GROUPS][MAX_LIMIT];
    int unsigned          ring_fill  [NUM_GROUPS];
    int unsigned          ring_head  [NUM_GROUPS];
    logic [WINDOW_W-1:0]  window_len [CFG_GROUPS];
    logic [LIMIT_W-1:0]   limit_val  [CFG_GROUPS];
    t_verdict             verdict_q  [$];
    int                   mismatches = 0;

    function automatic void flag_failure(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    function automatic t_verdict judge_request(logic cmd, logic [GROUP_W-1:0] grp,
                                               logic [WEIGHT_W-1:0] wt,
                                               logic [TIME_BITS-1:0] now);
        t_verdict             v;
        int unsigned          g;
        int unsigned          cap;
        int unsigned          fill;
        int unsigned          k;
        logic [TIME_BITS-1:0] dt;
        logic [63:0]          demand;
        logic [63:0]          allowance;
        logic                 refuse;
        v = '0;
        refuse = 1'b0;
        g = grp;
        if (cmd == CMD_CLEAR) begin
            for (k = 0; k < NUM_GROUPS; k++) begin
                ring_fill[k] = 0;
                ring_head[k] = 0;
            end
            return v;
        end
        if (g >= NUM_GROUPS)
            return v;
        cap = limit_val[g % CFG_GROUPS];
        if (cap == 0)
            cap = 1;
        else if (cap > MAX_LIMIT)
            cap = MAX_LIMIT;
        fill = ring_fill[g];
        if (wt != 0 && fill + wt >= cap) begin
            if (fill == 0) begin
                refuse = 1'b1;
            end else begin
                dt = now - stamp_ring[g][ring_head[g] % cap];
                demand = 64'(fill + wt) * 64'(window_len[g % CFG_GROUPS]);
                allowance = 64'(cap) * 64'(dt);
                refuse = (dt == 0) || (demand >= allowance);
            end
        end
        if (!refuse) begin
            for (k = 0; k < wt; k++) begin
                if (ring_fill[g] < cap) begin
                    stamp_ring[g][(ring_head[g] + ring_fill[g]) % cap] = now;
                    ring_fill[g]++;
                end else begin
                    stamp_ring[g][ring_head[g] % cap] = now;
                    ring_head[g] = (ring_head[g] + 1) % cap;
                end
            end
        end
        v.exceeded = refuse;
        v.fill = FILL_OUT_W'(ring_fill[g]);
        return v;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_verdict    want;
        int unsigned lg;
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                ring_fill[g] = 0;
                ring_head[g] = 0;
            end
            for (int g = 0; g < CFG_GROUPS; g++) begin
                window_len[g] = WINDOW_RESET;
                limit_val[g] = LIMIT_RESET;
            end
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index >= REG_WINDOW_G0 && i_cfg_index <= REG_WINDOW_G3) begin
                    window_len[i_cfg_index - REG_WINDOW_G0] = i_cfg_data[WINDOW_W-1:0];
                end else if (i_cfg_index >= REG_LIMIT_G0 && i_cfg_index <= REG_LIMIT_G3) begin
                    lg = i_cfg_index - REG_LIMIT_G0;
                    limit_val[lg] = i_cfg_data[LIMIT_W-1:0];
                    if (lg < NUM_GROUPS) begin
                        ring_fill[lg] = 0;
                        ring_head[lg] = 0;
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    flag_failure($sformatf("result with nothing pending: exceeded %0b fill %0d",
                                           i_exceeded, i_fill_count));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_exceeded !== want.exceeded)
                        flag_failure($sformatf("exceeded expected %0b got %0b",
                                               want.exceeded, i_exceeded));
                    if (i_fill_count !== want.fill)
                        flag_failure($sformatf("fill_count expected %0d got %0d",
                                               want.fill, i_fill_count));
                end
            end
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(judge_request(i_command, i_group, i_weight, i_now_ms));
        end
        o_pending <= verdict_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/tb_weighted_window_rate_limiter_top.sv
`timescale 1ns / 100ps
// Testbench top for the weighted window rate limiter: clock, reset, request and
// register stimulus, result back-pressure and the final verdict.
// Depends on wwrl_pkg, weighted_window_rate_limiter_top and wwrl_admission_checker.
module tb_weighted_window_rate_limiter_top;
    import wwrl_pkg::*;

    localparam int TIME_BITS       = DEF_TIME_BITS;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 400;
    localparam int DRAIN_CYCLES    = 150;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd8;
    localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  command = CMD_CHECK;
    logic [GROUP_W-1:0]    group = '0;
    logic [WEIGHT_W-1:0]   weight = '0;
    logic [TIME_BITS-1:0]  now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  exceeded;
    logic [FILL_OUT_W-1:0] fill_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    bit                    hold_off_req = 1'b0;
    logic [TIME_BITS-1:0]  now_cursor = '0;

    weighted_window_rate_limiter_top #(.TIME_BITS(TIME_BITS)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_command   (command),
        .i_group     (group),
        .i_weight    (weight),
        .i_now_ms    (now_ms),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_exceeded  (exceeded),
        .o_fill_count(fill_count),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wwrl_admission_checker #(.TIME_BITS(TIME_BITS)) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_command   (command),
        .i_group     (group),
        .i_weight    (weight),
        .i_now_ms    (now_ms),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_exceeded  (exceeded),
        .i_fill_count(fill_count),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        forever begin
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    task automatic issue(input logic cmd, input logic [GROUP_W-1:0] grp,
                         input logic [WEIGHT_W-1:0] wt, input logic [TIME_BITS-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        group <= grp;
        weight <= wt;
        now_ms <= t;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_group(input int g, input logic [CFG_DATA_W-1:0] window,
                             input logic [CFG_DATA_W-1:0] limit);
        write_reg(REG_WINDOW_G0 + CFG_IDX_W'(g), window);
        write_reg(REG_LIMIT_G0 + CFG_IDX_W'(g), limit);
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic random_burst(input int count, input int step_max, input bit squeeze);
        int                  r;
        logic [WEIGHT_W-1:0] wt;
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == count / 2)
                hold_off_req = 1'b1;
            r = $urandom_range(99);
            if (r < 2) begin
                issue(CMD_CLEAR, GROUP_W'($urandom), WEIGHT_W'($urandom), now_cursor);
            end else begin
                r = $urandom_range(99);
                if (r < 8)
                    wt = '0;
                else if (r < 90)
                    wt = WEIGHT_W'($urandom_range(1, 8));
                else if (r < 97)
                    wt = WEIGHT_W'($urandom_range(9, 64));
                else
                    wt = WEIGHT_W'($urandom_range(65, 127));
                r = $urandom_range(99);
                if (r < 12)
                    ;
                else if (r < 88)
                    now_cursor += $urandom_range(1, step_max);
                else if (r < 96)
                    now_cursor += $urandom_range(step_max, 20 * step_max);
                else if (r < 98)
                    now_cursor -= $urandom_range(1, step_max);
                else
                    now_cursor = TIME_BITS'({$urandom, $urandom});
                issue(CMD_CHECK, GROUP_W'($urandom_range(3)), wt, now_cursor);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 85;

        // reset settings: window 1000, limit 64
        issue(CMD_CHECK, 2'd0, 7'd0, 40'd0);
        issue(CMD_CHECK, 2'd0, 7'd64, 40'd5);
        issue(CMD_CHECK, 2'd0, 7'd63, 40'd5);
        issue(CMD_CHECK, 2'd0, 7'd1, 40'd5);
        issue(CMD_CLEAR, 2'd3, 7'd127, TIME_MAX);
        wait_idle(4);
        set_group(1, 24'd100, 24'd4);
        issue(CMD_CHECK, 2'd1, 7'd1, 40'd1000);
        issue(CMD_CHECK, 2'd1, 7'd2, 40'd1000);
        issue(CMD_CHECK, 2'd1, 7'd1, 40'd1000);
        issue(CMD_CHECK, 2'd1, 7'd1, 40'd1010);
        issue(CMD_CHECK, 2'd1, 7'd1, 40'd1200);
        issue(CMD_CHECK, 2'd1, 7'd127, TIME_MAX);
        issue(CMD_CHECK, 2'd1, 7'd1, 40'd0);
        issue(CMD_CHECK, 2'd1, 7'd0, 40'd0);
        wait_idle(4);
        set_group(2, 24'd0, 24'd2);
        set_group(3, 24'hFFFFFF, 24'd2);
        issue(CMD_CHECK, 2'd2, 7'd1, 40'd7);
        issue(CMD_CHECK, 2'd2, 7'd1, 40'd8);
        issue(CMD_CHECK, 2'd2, 7'd2, 40'd8);
        issue(CMD_CHECK, 2'd3, 7'd1, 40'd100);
        issue(CMD_CHECK, 2'd3, 7'd1, 40'd101);
        issue(CMD_CHECK, 2'd3, 7'd1, 40'd100 + (40'd1 << 39));
        wait_idle(4);
        write_reg(REG_LIMIT_G0 + CFG_IDX_W'(2), 24'd0);
        write_reg(REG_LIMIT_G0, 24'h0000E4);
        issue(CMD_CHECK, 2'd2, 7'd1, 40'd9);
        issue(CMD_CHECK, 2'd2, 7'd0, 40'd9);
        issue(CMD_CHECK, 2'd0, 7'd64, 40'd10);
        issue(CMD_CHECK, 2'd0, 7'd1, 40'd10);
        issue(CMD_CLEAR, 2'd0, 7'd0, 40'd10);
        issue(CMD_CHECK, 2'd1, 7'd1, 40'd11);

        wait_idle(4);
        for (int g = 0; g < CFG_GROUPS; g++)
            set_group(g, CFG_DATA_W'($urandom_range(1, 300)), CFG_DATA_W'($urandom_range(2, 16)));
        now_cursor = 40'd5000;
        random_burst(PHASE_ITEMS, 30, 1'b0);

        wait_idle(4);
        send_idle_pct = 85;
        recv_idle_pct = 20;
        set_group(0, 24'd1, 24'd8);
        set_group(1, 24'd0, 24'd4);
        set_group(2, CFG_DATA_W'($urandom_range(50, 500)), 24'd100);
        set_group(3, 24'd60, 24'd0);
        random_burst(PHASE_ITEMS, 10, 1'b1);

        wait_idle(4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_group(0, 24'hFFFFFF, 24'd2);
        set_group(1, 24'd1000, 24'd64);
        set_group(2, CFG_DATA_W'($urandom), 24'hFFFFFF);
        set_group(3, 24'd200, 24'd5);
        write_reg(REG_UNMAPPED + CFG_IDX_W'($urandom_range(7)), CFG_DATA_W'($urandom));
        random_burst(PHASE_ITEMS, 50, 1'b0);

        wait_idle(DRAIN_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
design/wwrl_pkg.sv
design/wwrl_ram.sv
design/wwrl_dp.sv
design/wwrl_ctrl.sv
design/weighted_window_rate_limiter_top.sv
tb/wwrl_admission_checker.sv
tb/tb_weighted_window_rate_limiter_top.sv
